// ===== hdl/thdtk_pkg.sv =====
// Package for the tap / hold / double-tap key unit.
// Slot record, operation, mode and event codes, and timer helpers.
// No dependencies.
package thdtk_pkg;

	localparam int CNT_W = 17;
	localparam int TICK_W = 16;

	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_P1     = 3'd1;
	localparam logic [2:0] MODE_WAIT   = 3'd2;
	localparam logic [2:0] MODE_P2     = 3'd3;
	localparam logic [2:0] MODE_REPEAT = 3'd4;

	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_TAP  = 2'd1;
	localparam logic [1:0] PEND_CAPS = 2'd2;

	localparam logic [1:0] EV_BS_DOWN      = 2'd0;
	localparam logic [1:0] EV_BS_UP        = 2'd1;
	localparam logic [1:0] EV_CAPS_PRESS   = 2'd2;
	localparam logic [1:0] EV_CAPS_RELEASE = 2'd3;

	localparam logic [1:0] REG_HOLD     = 2'd0;
	localparam logic [1:0] REG_FOLLOWUP = 2'd1;
	localparam logic [1:0] REG_TAPREL   = 2'd2;

	typedef struct packed {
		logic [2:0]       mode;
		logic [1:0]       pend;
		logic [CNT_W-1:0] hold;
		logic [CNT_W-1:0] fu;
		logic [CNT_W-1:0] rel;
	} slot_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] slot;
	} ev_t;

	// running timer holds remaining ticks plus one; zero is stopped
	function automatic logic [CNT_W-1:0] tmr_start(logic [CNT_W-1:0] c,
			logic [TICK_W-1:0] d);
		return (c == '0) ? ({1'b0, d} + CNT_W'(1)) : c;
	endfunction

	function automatic logic tmr_expire(logic [CNT_W-1:0] c);
		return (c != '0) && (c <= CNT_W'(2));
	endfunction

	function automatic logic [CNT_W-1:0] tmr_tick(logic [CNT_W-1:0] c);
		return (c <= CNT_W'(2)) ? '0 : (c - CNT_W'(1));
	endfunction

endpackage

// ===== hdl/tap_hold_double_tap_key_unit.sv =====
// Tap / hold / double-tap key decoder top level.
// Per-slot state memory walked by one shared slot update unit under a sequencer.
// Depends on thdtk_pkg.
//
// A press or release on a slot below SLOTS keeps busy through read, update and
// flush states; a tick walks every slot through the one update unit (memory
// read, then update and write-back, plus a push state for two events), then a
// final flush state. Results leave at most one per cycle on result_strobe, one
// beat each, and cannot be held off; the final beat of an item carries last. An
// item that causes nothing (tick aside: an unknown operation or a position at
// or above SLOTS) is taken without raising busy. Configuration is written
// through cfg_wen/cfg_index/cfg_wdata while idle; the block does not enforce it.
module tap_hold_double_tap_key_unit
	import thdtk_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  position,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	output logic        result_strobe,
	output logic [1:0]  event_kind,
	output logic [4:0]  key_position,
	output logic        last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_PROC,
		ST_PUSH2,
		ST_FLUSH
	} state_t;

	state_t            state_q;
	logic [1:0]        op_q;
	logic [IDX_W-1:0]  idx_q;
	logic [15:0]       hold_ticks_q;
	logic [15:0]       fu_ticks_q;
	logic [15:0]       rel_ticks_q;
	logic [SLOTS-1:0]  vld_q;
	slot_t             mem [SLOTS];
	slot_t             rd_q;
	logic              rd_vld_q;
	ev_t               hld_q;
	logic              hld_vld_q;
	ev_t               ev2_q;
	logic              strobe_q;
	ev_t               out_q;
	logic              last_q;

	slot_t  cur;
	slot_t  nxt;
	logic   ev_a_vld;
	logic   ev_b_vld;
	ev_t    ev_a;
	ev_t    ev_b;
	logic   push_vld;
	ev_t    push_ev;
	logic   more_slots;
	logic   in_range;
	logic   rel_fire;
	logic   hold_fire;
	logic   rel_ev;
	logic   hold_ev;
	logic [4:0] slot5;

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign event_kind    = out_q.kind;
	assign key_position  = out_q.slot;
	assign last          = last_q;

	assign in_range   = ({1'b0, position} < 9'(SLOTS));
	assign more_slots = (op_q == OP_TICK) && (idx_q != IDX_W'(SLOTS - 1));
	assign slot5      = 5'(idx_q);

	// shared slot update unit
	always_comb begin
		cur       = rd_vld_q ? rd_q : '0;
		nxt       = cur;
		rel_fire  = 1'b0;
		hold_fire = 1'b0;
		rel_ev    = 1'b0;
		hold_ev   = 1'b0;
		ev_a_vld  = 1'b0;
		ev_b_vld  = 1'b0;
		ev_a      = '{kind: EV_BS_DOWN, slot: slot5};
		ev_b      = '{kind: EV_BS_DOWN, slot: slot5};
		case (op_q)
			OP_TICK: begin
				rel_fire  = tmr_expire(cur.rel);
				hold_fire = tmr_expire(cur.hold);
				nxt.rel   = tmr_tick(cur.rel);
				nxt.hold  = tmr_tick(cur.hold);
				nxt.fu    = tmr_tick(cur.fu);
				if (rel_fire) begin
					nxt.pend = PEND_NONE;
					if (cur.pend == PEND_TAP || cur.pend == PEND_CAPS) begin
						rel_ev = 1'b1;
					end
				end
				if (hold_fire && (cur.mode == MODE_P1 || cur.mode == MODE_P2)) begin
					nxt.mode = MODE_REPEAT;
					hold_ev  = 1'b1;
				end
				if (tmr_expire(cur.fu) && cur.mode == MODE_WAIT) begin
					nxt.mode = MODE_IDLE;
				end
				ev_a_vld = rel_ev || hold_ev;
				ev_b_vld = rel_ev && hold_ev;
				if (rel_ev) begin
					ev_a.kind = (cur.pend == PEND_TAP) ? EV_BS_UP : EV_CAPS_RELEASE;
				end
			end
			OP_PRESS: begin
				if (cur.mode == MODE_IDLE) begin
					nxt.mode = MODE_P1;
					nxt.hold = tmr_start(cur.hold, hold_ticks_q);
				end else if (cur.mode == MODE_WAIT) begin
					nxt.fu   = '0;
					nxt.mode = MODE_P2;
					nxt.hold = tmr_start(cur.hold, hold_ticks_q);
				end
			end
			OP_RELEASE: begin
				if (cur.mode == MODE_P1) begin
					nxt.hold  = '0;
					nxt.mode  = MODE_WAIT;
					nxt.pend  = PEND_TAP;
					nxt.rel   = tmr_start(cur.rel, rel_ticks_q);
					nxt.fu    = tmr_start(cur.fu, fu_ticks_q);
					ev_a_vld  = 1'b1;
					ev_a.kind = EV_BS_DOWN;
				end else if (cur.mode == MODE_P2) begin
					nxt.hold  = '0;
					nxt.mode  = MODE_IDLE;
					nxt.pend  = PEND_CAPS;
					nxt.rel   = tmr_start(cur.rel, rel_ticks_q);
					ev_a_vld  = 1'b1;
					ev_a.kind = EV_CAPS_PRESS;
				end else if (cur.mode == MODE_REPEAT) begin
					nxt.mode  = MODE_IDLE;
					ev_a_vld  = 1'b1;
					ev_a.kind = EV_BS_UP;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	always_comb begin
		push_vld = (state_q == ST_PROC && ev_a_vld) || (state_q == ST_PUSH2);
		push_ev  = (state_q == ST_PUSH2) ? ev2_q : ev_a;
	end

	// slot state memory
	always_ff @(posedge clk) begin
		if (state_q == ST_PROC) begin
			mem[idx_q] <= nxt;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_PRESS;
			idx_q        <= '0;
			hold_ticks_q <= 16'd200;
			fu_ticks_q   <= 16'd300;
			rel_ticks_q  <= 16'd30;
			vld_q        <= '0;
			rd_vld_q     <= 1'b0;
			hld_vld_q    <= 1'b0;
			strobe_q     <= 1'b0;
			last_q       <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			rd_vld_q <= vld_q[idx_q];
			if (cfg_wen) begin
				case (cfg_index)
					REG_HOLD:     hold_ticks_q <= cfg_wdata;
					REG_FOLLOWUP: fu_ticks_q   <= cfg_wdata;
					REG_TAPREL:   rel_ticks_q  <= cfg_wdata;
					default:      ;
				endcase
			end
			// one-deep holding stage lets the final beat carry last
			if (push_vld) begin
				if (hld_vld_q) begin
					strobe_q <= 1'b1;
					out_q    <= hld_q;
					last_q   <= 1'b0;
				end
				hld_q     <= push_ev;
				hld_vld_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q <= operation;
						if (operation == OP_TICK) begin
							idx_q   <= '0;
							state_q <= ST_RD;
						end else if ((operation == OP_PRESS || operation == OP_RELEASE)
								&& in_range) begin
							idx_q   <= IDX_W'(position);
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_PROC;
				end
				ST_PROC: begin
					vld_q[idx_q] <= 1'b1;
					if (ev_b_vld) begin
						ev2_q   <= ev_b;
						state_q <= ST_PUSH2;
					end else if (more_slots) begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_RD;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_PUSH2: begin
					if (more_slots) begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_RD;
					end else begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (hld_vld_q) begin
						strobe_q  <= 1'b1;
						out_q     <= hld_q;
						last_q    <= 1'b1;
						hld_vld_q <= 1'b0;
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_TICK |=> busy)
		else $error("tick accepted but block not busy");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && last |=> !result_strobe)
		else $error("beat follows the final beat of an item");

	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !last |-> busy)
		else $error("non-final beat outside an item");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hld_vld_q)
		else $error("held event left over in idle");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for tap_hold_double_tap_key_unit: press, release and tick beats are
// driven in random bursts, and a scoreboard that tracks every slot predicts each event beat.
// Depends on thdtk_pkg and the unit's RTL.
module testbench;
	import thdtk_pkg::*;

	localparam int NSLOT = 32;
	localparam int SETTLE = 3 * NSLOT + 8;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam logic [1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [4:0] slot;
		logic       last;
	} key_beat_t;

	class key_event_book;
		logic [2:0]  mode [NSLOT];
		logic [1:0]  pend [NSLOT];
		logic [16:0] hold_cnt [NSLOT];
		logic [16:0] fu_cnt [NSLOT];
		logic [16:0] rel_cnt [NSLOT];
		logic [15:0] hold_ticks;
		logic [15:0] followup_ticks;
		logic [15:0] tap_rel_ticks;
		key_beat_t   due [$];
		int          errors;

		function new();
			hold_ticks = 16'd200;
			followup_ticks = 16'd300;
			tap_rel_ticks = 16'd30;
			errors = 0;
			foreach (mode[i]) begin
				mode[i] = MODE_IDLE;
				pend[i] = PEND_NONE;
				hold_cnt[i] = '0;
				fu_cnt[i] = '0;
				rel_cnt[i] = '0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_HOLD:     hold_ticks = val;
				REG_FOLLOWUP: followup_ticks = val;
				REG_TAPREL:   tap_rel_ticks = val;
				default: ;
			endcase
		endfunction

		// count is remaining ticks plus one, zero when stopped
		function logic [16:0] armed(logic [16:0] c, logic [15:0] d);
			return (c != 17'd0) ? c : 17'(d) + 17'd1;
		endfunction

		function logic fires(logic [16:0] c);
			return (c == 17'd1) || (c == 17'd2);
		endfunction

		function logic [16:0] stepped(logic [16:0] c);
			return (c > 17'd2) ? c - 17'd1 : 17'd0;
		endfunction

		function void note_beat(logic [1:0] op, logic [7:0] pos);
			key_beat_t  burst [$];
			key_beat_t  b;
			logic [4:0] s;
			if (op == OP_TICK) begin
				for (int i = 0; i < NSLOT; i++) begin
					s = 5'(i);
					if (fires(rel_cnt[i])) begin
						if (pend[i] == PEND_TAP)
							burst.push_back('{EV_BS_UP, s, 1'b0});
						else if (pend[i] == PEND_CAPS)
							burst.push_back('{EV_CAPS_RELEASE, s, 1'b0});
						pend[i] = PEND_NONE;
					end
					rel_cnt[i] = stepped(rel_cnt[i]);
					if (fires(hold_cnt[i]) && (mode[i] == MODE_P1 || mode[i] == MODE_P2)) begin
						mode[i] = MODE_REPEAT;
						burst.push_back('{EV_BS_DOWN, s, 1'b0});
					end
					hold_cnt[i] = stepped(hold_cnt[i]);
					if (fires(fu_cnt[i]) && mode[i] == MODE_WAIT)
						mode[i] = MODE_IDLE;
					fu_cnt[i] = stepped(fu_cnt[i]);
				end
			end else if ((op == OP_PRESS || op == OP_RELEASE) && pos < NSLOT) begin
				s = pos[4:0];
				if (op == OP_PRESS) begin
					if (mode[s] == MODE_IDLE) begin
						mode[s] = MODE_P1;
						hold_cnt[s] = armed(hold_cnt[s], hold_ticks);
					end else if (mode[s] == MODE_WAIT) begin
						fu_cnt[s] = '0;
						mode[s] = MODE_P2;
						hold_cnt[s] = armed(hold_cnt[s], hold_ticks);
					end
				end else begin
					if (mode[s] == MODE_P1) begin
						hold_cnt[s] = '0;
						mode[s] = MODE_WAIT;
						burst.push_back('{EV_BS_DOWN, s, 1'b0});
						pend[s] = PEND_TAP;
						rel_cnt[s] = armed(rel_cnt[s], tap_rel_ticks);
						fu_cnt[s] = armed(fu_cnt[s], followup_ticks);
					end else if (mode[s] == MODE_P2) begin
						hold_cnt[s] = '0;
						mode[s] = MODE_IDLE;
						burst.push_back('{EV_CAPS_PRESS, s, 1'b0});
						pend[s] = PEND_CAPS;
						rel_cnt[s] = armed(rel_cnt[s], tap_rel_ticks);
					end else if (mode[s] == MODE_REPEAT) begin
						burst.push_back('{EV_BS_UP, s, 1'b0});
						mode[s] = MODE_IDLE;
					end
				end
			end
			if (burst.size() != 0) begin
				b = burst.pop_back();
				b.last = 1'b1;
				burst.push_back(b);
			end
			foreach (burst[i])
				due.push_back(burst[i]);
		endfunction

		function void check_beat(logic [1:0] kind, logic [4:0] slot, logic fin);
			key_beat_t want;
			if (due.size() == 0) begin
				$error("unexpected beat: event_kind %0d key_position %0d last %0b",
					kind, slot, fin);
				errors++;
				return;
			end
			want = due.pop_front();
			if (kind !== want.kind) begin
				$error("event_kind: expected %0d, got %0d", want.kind, kind);
				errors++;
			end
			if (slot !== want.slot) begin
				$error("key_position: expected %0d, got %0d", want.slot, slot);
				errors++;
			end
			if (fin !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, fin);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  operation;
	logic [7:0]  position;
	logic        cfg_wen;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        result_strobe;
	logic [1:0]  event_kind;
	logic [4:0]  key_position;
	logic        last;

	key_event_book book;
	int          items_sent;
	int          burst_left;
	logic [15:0] plan [6][3] = '{
		'{16'd0, 16'd0, 16'd0},
		'{16'd1, 16'd3, 16'd1},
		'{16'd4, 16'd6, 16'd2},
		'{16'd2, 16'hFFFF, 16'd0},
		'{16'd3, 16'd2, 16'd5},
		'{16'hFFFF, 16'hFFFF, 16'hFFFF}
	};

	tap_hold_double_tap_key_unit #(.SLOTS(NSLOT)) uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && result_strobe)
			book.check_beat(event_kind, key_position, last);
	end

	task automatic send_item(input logic [1:0] op, input logic [7:0] pos);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 4);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		operation <= op;
		position <= pos;
		do @(posedge clk); while (busy);
		book.note_beat(op, pos);
		if (op == OP_TICK || ((op == OP_PRESS || op == OP_RELEASE) && pos < NSLOT))
			items_sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (book.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		book.set_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic random_step(input logic [15:0] hold_now);
		logic [7:0] s;
		int         pick;
		s = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, NSLOT - 1))
			: 8'($urandom_range(0, 3));
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: send_item(2'($urandom_range(0, 3)), 8'($urandom));
			2, 3, 4: begin
				send_item(OP_PRESS, s);
				repeat ($urandom_range(0, 2)) send_item(OP_TICK, 8'($urandom));
				send_item(OP_RELEASE, s);
			end
			5, 6: begin
				send_item(OP_PRESS, s);
				repeat ((hold_now < 16'd6) ? hold_now + 1 : $urandom_range(1, 6))
					send_item(OP_TICK, 8'($urandom));
				send_item(OP_RELEASE, s);
			end
			7, 8: begin
				send_item(OP_PRESS, s);
				send_item(OP_RELEASE, s);
				repeat ($urandom_range(0, 2)) send_item(OP_TICK, 8'($urandom));
				send_item(OP_PRESS, s);
				send_item(OP_RELEASE, s);
			end
			default: repeat ($urandom_range(1, 5)) send_item(OP_TICK, 8'($urandom));
		endcase
		repeat ($urandom_range(0, 2)) send_item(OP_TICK, 8'($urandom));
		if ($urandom_range(0, 39) == 0)
			drain();
	endtask

	initial begin
		book = new();
		items_sent = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operation = OP_PRESS;
		position = 8'd0;
		cfg_wen = 1'b0;
		cfg_index = REG_HOLD;
		cfg_wdata = 16'd0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ignored beats, tap, double tap with pending release overwritten
		send_item(OP_PRESS, 8'd32);
		send_item(OP_RELEASE, 8'd255);
		send_item(OP_NONE, 8'd0);
		send_item(OP_PRESS, 8'd31);
		send_item(OP_RELEASE, 8'd31);
		send_item(OP_RELEASE, 8'd5);
		send_item(OP_PRESS, 8'd31);
		send_item(OP_RELEASE, 8'd31);
		send_item(OP_TICK, 8'hFF);
		drain();

		write_reg(REG_HOLD, 16'd1);
		write_reg(REG_FOLLOWUP, 16'd2);
		write_reg(REG_TAPREL, 16'd0);
		write_reg(REG_NONE, 16'hFFFF);
		// hold, stray press while repeating, hold from second press, follow-up timeout
		send_item(OP_PRESS, 8'd0);
		send_item(OP_TICK, 8'h00);
		send_item(OP_PRESS, 8'd0);
		send_item(OP_RELEASE, 8'd0);
		send_item(OP_PRESS, 8'd1);
		send_item(OP_RELEASE, 8'd1);
		send_item(OP_TICK, 8'h55);
		send_item(OP_PRESS, 8'd1);
		send_item(OP_TICK, 8'hAA);
		send_item(OP_RELEASE, 8'd1);
		send_item(OP_PRESS, 8'd2);
		send_item(OP_RELEASE, 8'd2);
		send_item(OP_TICK, 8'h0F);
		send_item(OP_TICK, 8'hF0);
		send_item(OP_PRESS, 8'd2);
		send_item(OP_RELEASE, 8'd2);

		for (int p = 0; p < 6; p++) begin
			drain();
			write_reg(REG_TAPREL, plan[p][2]);
			write_reg(REG_HOLD, plan[p][0]);
			write_reg(REG_FOLLOWUP, plan[p][1]);
			while (items_sent < 25 + 34 * (p + 1))
				random_step(plan[p][0]);
		end

		drain();
		if (book.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
